// ===== src/wlqe_pkg.sv =====
// ----------------------------------------------------------------------------
// wlqe_pkg: shared types and constants for the line quad expander
// Widths of the datapath, reset value of the half width and the stage
// payload that runs next to the CORDIC datapath.
// ----------------------------------------------------------------------------
package wlqe_pkg;

  localparam int DEF_CORDIC_STAGES = 16;
  localparam int DEF_FRACTION_BITS = 16;

  localparam int COORD_W = 32;
  localparam int DIFF_W  = 33;
  localparam int VEC_W   = 36;
  localparam int HW_W    = 31;

  localparam logic [HW_W-1:0] HW_RESET = 31'd65536;
  // 1/K of the CORDIC gain, Q0.32
  localparam logic [31:0]     KINV_Q32 = 32'd2608131496;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] start_z;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] end_z;
    logic                      last_line;
    logic                      zero_len;
    logic                      flip;
  } side_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] c0_x;
    logic signed [COORD_W-1:0] c0_y;
    logic signed [COORD_W-1:0] c1_x;
    logic signed [COORD_W-1:0] c1_y;
    logic signed [COORD_W-1:0] c2_x;
    logic signed [COORD_W-1:0] c2_y;
    logic signed [COORD_W-1:0] c3_x;
    logic signed [COORD_W-1:0] c3_y;
  } quad_t;

endpackage

// ===== src/wide_line_quad_expander.sv =====
// ----------------------------------------------------------------------------
// wide_line_quad_expander: line segment to screen-plane quad corners
// Pipeline: CORDIC_STAGES + 5 register stages from the front stages through
// the CORDIC chain to the finish stages. Throughput: one request per cycle
// while out_ready holds, through the unrolled CORDIC stage chain.
// Reset: sync active-low rst_n empties every stage; half_width returns to 1.0.
// ----------------------------------------------------------------------------
module wide_line_quad_expander #(
  parameter int CORDIC_STAGES = wlqe_pkg::DEF_CORDIC_STAGES,
  parameter int FRACTION_BITS = wlqe_pkg::DEF_FRACTION_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [wlqe_pkg::HW_W-1:0]        cfg_wr_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [31:0]               in_start_x,
  input  logic signed [31:0]               in_start_y,
  input  logic signed [31:0]               in_start_z,
  input  logic signed [31:0]               in_end_x,
  input  logic signed [31:0]               in_end_y,
  input  logic signed [31:0]               in_end_z,
  input  logic                             in_last_line,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [31:0]               out_corner0_x,
  output logic signed [31:0]               out_corner0_y,
  output logic signed [31:0]               out_corner1_x,
  output logic signed [31:0]               out_corner1_y,
  output logic signed [31:0]               out_corner2_x,
  output logic signed [31:0]               out_corner2_y,
  output logic signed [31:0]               out_corner3_x,
  output logic signed [31:0]               out_corner3_y,
  output logic signed [31:0]               out_near_depth,
  output logic signed [31:0]               out_far_depth,
  output logic                             out_batch_end
);

  localparam int RW = wlqe_pkg::DIFF_W + FRACTION_BITS;
  localparam int VW = wlqe_pkg::VEC_W;

  logic [wlqe_pkg::HW_W-1:0] hw_r;
  logic [63:0]               w_prod;
  logic signed [RW-1:0]      w_r, w_nxt;

  wlqe_pkg::side_t      in_side;
  wlqe_pkg::side_t      cs_side [CORDIC_STAGES+1];
  logic signed [VW-1:0] cs_vx [CORDIC_STAGES+1];
  logic signed [VW-1:0] cs_vy [CORDIC_STAGES+1];
  logic signed [RW-1:0] cs_rx [CORDIC_STAGES+1];
  logic signed [RW-1:0] cs_ry [CORDIC_STAGES+1];
  logic [CORDIC_STAGES:0] cs_v, cs_rdy;

  wlqe_pkg::side_t out_side;
  wlqe_pkg::quad_t out_quad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r <= wlqe_pkg::HW_RESET;
    end else if (cfg_wr_en) begin
      hw_r <= cfg_wr_data;
    end
  end

  // rotation operand: half_width / K with FRACTION_BITS guard bits
  assign w_prod = {33'b0, hw_r} * {32'b0, wlqe_pkg::KINV_Q32};
  assign w_nxt  = RW'(w_prod >> (32 - FRACTION_BITS));

  always_ff @(posedge clk) begin
    w_r <= w_nxt;
  end

  always_comb begin
    in_side           = '0;
    in_side.start_x   = in_start_x;
    in_side.start_y   = in_start_y;
    in_side.start_z   = in_start_z;
    in_side.end_x     = in_end_x;
    in_side.end_y     = in_end_y;
    in_side.end_z     = in_end_z;
    in_side.last_line = in_last_line;
  end

  wlqe_front #(.RW(RW)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_side  (in_side),
    .w        (w_r),
    .dn_valid (cs_v[0]),
    .dn_ready (cs_rdy[0]),
    .dn_side  (cs_side[0]),
    .dn_vx    (cs_vx[0]),
    .dn_vy    (cs_vy[0]),
    .dn_rx    (cs_rx[0]),
    .dn_ry    (cs_ry[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    wlqe_cordic_stage #(.SHIFT(i), .RW(RW)) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (cs_v[i]),
      .up_ready (cs_rdy[i]),
      .up_side  (cs_side[i]),
      .up_vx    (cs_vx[i]),
      .up_vy    (cs_vy[i]),
      .up_rx    (cs_rx[i]),
      .up_ry    (cs_ry[i]),
      .dn_valid (cs_v[i+1]),
      .dn_ready (cs_rdy[i+1]),
      .dn_side  (cs_side[i+1]),
      .dn_vx    (cs_vx[i+1]),
      .dn_vy    (cs_vy[i+1]),
      .dn_rx    (cs_rx[i+1]),
      .dn_ry    (cs_ry[i+1])
    );
  end

  wlqe_finish #(.RW(RW), .FB(FRACTION_BITS)) u_finish (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (cs_v[CORDIC_STAGES]),
    .up_ready   (cs_rdy[CORDIC_STAGES]),
    .up_side    (cs_side[CORDIC_STAGES]),
    .up_rx      (cs_rx[CORDIC_STAGES]),
    .up_ry      (cs_ry[CORDIC_STAGES]),
    .half_width (hw_r),
    .dn_valid   (out_valid),
    .dn_ready   (out_ready),
    .dn_side    (out_side),
    .dn_quad    (out_quad)
  );

  assign out_corner0_x  = out_quad.c0_x;
  assign out_corner0_y  = out_quad.c0_y;
  assign out_corner1_x  = out_quad.c1_x;
  assign out_corner1_y  = out_quad.c1_y;
  assign out_corner2_x  = out_quad.c2_x;
  assign out_corner2_y  = out_quad.c2_y;
  assign out_corner3_x  = out_quad.c3_x;
  assign out_corner3_y  = out_quad.c3_y;
  assign out_near_depth = out_side.start_z;
  assign out_far_depth  = out_side.end_z;
  assign out_batch_end  = out_side.last_line;

  // an empty or draining output stage must open the whole ready chain
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("ready chain closed while the output stage can advance");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

// ===== src/wlqe_front.sv =====
// ----------------------------------------------------------------------------
// wlqe_front: segment difference and CORDIC preparation
// Two stages: end minus start, then zero-length detect, left half-plane
// fold and load of the rotation operand.
// ----------------------------------------------------------------------------
module wlqe_front #(
  parameter int RW = 49
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              up_valid,
  output logic                              up_ready,
  input  wlqe_pkg::side_t                   up_side,
  input  logic signed [RW-1:0]              w,
  output logic                              dn_valid,
  input  logic                              dn_ready,
  output wlqe_pkg::side_t                   dn_side,
  output logic signed [wlqe_pkg::VEC_W-1:0] dn_vx,
  output logic signed [wlqe_pkg::VEC_W-1:0] dn_vy,
  output logic signed [RW-1:0]              dn_rx,
  output logic signed [RW-1:0]              dn_ry
);

  localparam int DW = wlqe_pkg::DIFF_W;
  localparam int VW = wlqe_pkg::VEC_W;

  logic                 a_v_r;
  wlqe_pkg::side_t      a_side_r;
  logic signed [DW-1:0] a_dx_r, a_dy_r;
  logic signed [DW-1:0] dx_nxt, dy_nxt;
  logic                 a_rdy;

  logic                 b_v_r;
  wlqe_pkg::side_t      b_side_r;
  wlqe_pkg::side_t      b_side_nxt;
  logic signed [VW-1:0] b_vx_r, b_vy_r, vx_nxt, vy_nxt;
  logic signed [VW-1:0] dx_ext, dy_ext;
  logic signed [RW-1:0] b_rx_r;
  logic                 b_rdy;

  assign a_rdy    = !a_v_r || b_rdy;
  assign b_rdy    = !b_v_r || dn_ready;
  assign up_ready = a_rdy;

  assign dx_nxt = {up_side.end_x[31], up_side.end_x} - {up_side.start_x[31], up_side.start_x};
  assign dy_nxt = {up_side.end_y[31], up_side.end_y} - {up_side.start_y[31], up_side.start_y};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (a_rdy) begin
      a_v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy) begin
      a_side_r <= up_side;
      a_dx_r   <= dx_nxt;
      a_dy_r   <= dy_nxt;
    end
  end

  assign dx_ext = {{(VW-DW){a_dx_r[DW-1]}}, a_dx_r};
  assign dy_ext = {{(VW-DW){a_dy_r[DW-1]}}, a_dy_r};

  // fold the left half-plane by a half turn
  always_comb begin
    b_side_nxt          = a_side_r;
    b_side_nxt.zero_len = (a_dx_r == '0) && (a_dy_r == '0);
    b_side_nxt.flip     = a_dx_r[DW-1];
    vx_nxt              = a_dx_r[DW-1] ? -dx_ext : dx_ext;
    vy_nxt              = a_dx_r[DW-1] ? -dy_ext : dy_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (b_rdy) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_rdy) begin
      b_side_r <= b_side_nxt;
      b_vx_r   <= vx_nxt;
      b_vy_r   <= vy_nxt;
      b_rx_r   <= w;
    end
  end

  assign dn_valid = b_v_r;
  assign dn_side  = b_side_r;
  assign dn_vx    = b_vx_r;
  assign dn_vy    = b_vy_r;
  assign dn_rx    = b_rx_r;
  assign dn_ry    = '0;

endmodule

// ===== src/wlqe_cordic_stage.sv =====
// ----------------------------------------------------------------------------
// wlqe_cordic_stage: one registered CORDIC iteration
// The vectoring half picks the direction from the sign of y; the rotation
// half turns the offset vector the opposite way in the same stage.
// ----------------------------------------------------------------------------
module wlqe_cordic_stage #(
  parameter int SHIFT = 0,
  parameter int RW    = 49
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              up_valid,
  output logic                              up_ready,
  input  wlqe_pkg::side_t                   up_side,
  input  logic signed [wlqe_pkg::VEC_W-1:0] up_vx,
  input  logic signed [wlqe_pkg::VEC_W-1:0] up_vy,
  input  logic signed [RW-1:0]              up_rx,
  input  logic signed [RW-1:0]              up_ry,
  output logic                              dn_valid,
  input  logic                              dn_ready,
  output wlqe_pkg::side_t                   dn_side,
  output logic signed [wlqe_pkg::VEC_W-1:0] dn_vx,
  output logic signed [wlqe_pkg::VEC_W-1:0] dn_vy,
  output logic signed [RW-1:0]              dn_rx,
  output logic signed [RW-1:0]              dn_ry
);

  localparam int VW = wlqe_pkg::VEC_W;

  logic                 v_r;
  wlqe_pkg::side_t      side_r;
  logic signed [VW-1:0] vx_r, vy_r, vx_nxt, vy_nxt;
  logic signed [RW-1:0] rx_r, ry_r, rx_nxt, ry_nxt;
  logic signed [VW-1:0] vx_sh, vy_sh;
  logic signed [RW-1:0] rx_sh, ry_sh;
  logic                 up_dir;
  logic                 rdy;

  assign rdy      = !v_r || dn_ready;
  assign up_ready = rdy;

  assign up_dir = !up_vy[VW-1];
  assign vx_sh  = up_vx >>> SHIFT;
  assign vy_sh  = up_vy >>> SHIFT;
  assign rx_sh  = up_rx >>> SHIFT;
  assign ry_sh  = up_ry >>> SHIFT;

  always_comb begin
    if (up_dir) begin
      vx_nxt = up_vx + vy_sh;
      vy_nxt = up_vy - vx_sh;
      rx_nxt = up_rx - ry_sh;
      ry_nxt = up_ry + rx_sh;
    end else begin
      vx_nxt = up_vx - vy_sh;
      vy_nxt = up_vy + vx_sh;
      rx_nxt = up_rx + ry_sh;
      ry_nxt = up_ry - rx_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy) begin
      side_r <= up_side;
      vx_r   <= vx_nxt;
      vy_r   <= vy_nxt;
      rx_r   <= rx_nxt;
      ry_r   <= ry_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_side  = side_r;
  assign dn_vx    = vx_r;
  assign dn_vy    = vy_r;
  assign dn_rx    = rx_r;
  assign dn_ry    = ry_r;

endmodule

// ===== src/wlqe_finish.sv =====
// ----------------------------------------------------------------------------
// wlqe_finish: rounding, offset select and saturated corner sums
// Three stages: round off the guard bits, form the perpendicular offset
// (half-turn undo, zero-length case), then add and clamp the four corners.
// ----------------------------------------------------------------------------
module wlqe_finish #(
  parameter int RW = 49,
  parameter int FB = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             up_valid,
  output logic                             up_ready,
  input  wlqe_pkg::side_t                  up_side,
  input  logic signed [RW-1:0]             up_rx,
  input  logic signed [RW-1:0]             up_ry,
  input  logic [wlqe_pkg::HW_W-1:0]        half_width,
  output logic                             dn_valid,
  input  logic                             dn_ready,
  output wlqe_pkg::side_t                  dn_side,
  output wlqe_pkg::quad_t                  dn_quad
);

  localparam int CW    = wlqe_pkg::COORD_W;
  localparam int RX_W  = RW - FB;
  localparam int OFF_W = RX_W + 1;
  localparam int SUM_W = OFF_W + 1;
  localparam logic signed [RW-1:0] HALF = {{(RW-1){1'b0}}, 1'b1} << (FB-1);

  function automatic logic signed [CW-1:0] sat(input logic signed [SUM_W-1:0] v);
    logic signed [CW-1:0] res;
    if (v[SUM_W-1:CW-1] == '0 || v[SUM_W-1:CW-1] == '1) begin
      res = v[CW-1:0];
    end else if (v[SUM_W-1]) begin
      res = {1'b1, {(CW-1){1'b0}}};
    end else begin
      res = {1'b0, {(CW-1){1'b1}}};
    end
    return res;
  endfunction

  function automatic logic signed [SUM_W-1:0] ext_c(input logic signed [CW-1:0] v);
    return {{(SUM_W-CW){v[CW-1]}}, v};
  endfunction

  function automatic logic signed [SUM_W-1:0] ext_o(input logic signed [OFF_W-1:0] v);
    return {v[OFF_W-1], v};
  endfunction

  // round stage
  logic                   r_v_r;
  wlqe_pkg::side_t        r_side_r;
  logic signed [RW-1:0]   rnd_x, rnd_y;
  logic signed [RX_W-1:0] r_x_r, r_y_r;
  logic                   r_rdy;

  // offset stage
  logic                    o_v_r;
  wlqe_pkg::side_t         o_side_r;
  logic signed [OFF_W-1:0] o_x_r, o_y_r, ox_nxt, oy_nxt;
  logic signed [OFF_W-1:0] cx_ext, cy_ext;
  logic                    o_rdy;

  // corner stage
  logic                    c_v_r;
  wlqe_pkg::side_t         c_side_r;
  wlqe_pkg::quad_t         c_quad_r, quad_nxt;
  logic                    c_rdy;

  assign r_rdy    = !r_v_r || o_rdy;
  assign o_rdy    = !o_v_r || c_rdy;
  assign c_rdy    = !c_v_r || dn_ready;
  assign up_ready = r_rdy;

  assign rnd_x = (up_rx + HALF) >>> FB;
  assign rnd_y = (up_ry + HALF) >>> FB;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_v_r <= 1'b0;
      o_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      if (r_rdy) begin
        r_v_r <= up_valid;
      end
      if (o_rdy) begin
        o_v_r <= r_v_r;
      end
      if (c_rdy) begin
        c_v_r <= o_v_r;
      end
    end
  end

  assign cx_ext = {r_x_r[RX_W-1], r_x_r};
  assign cy_ext = {r_y_r[RX_W-1], r_y_r};

  // off = (-sin, cos) scaled; undo the half turn for the left half-plane
  always_comb begin
    if (r_side_r.zero_len) begin
      ox_nxt = '0;
      oy_nxt = OFF_W'({1'b0, half_width});
    end else if (r_side_r.flip) begin
      ox_nxt = cy_ext;
      oy_nxt = -cx_ext;
    end else begin
      ox_nxt = -cy_ext;
      oy_nxt = cx_ext;
    end
  end

  always_comb begin
    quad_nxt.c0_x = sat(ext_c(o_side_r.end_x)   - ext_o(o_x_r));
    quad_nxt.c0_y = sat(ext_c(o_side_r.end_y)   - ext_o(o_y_r));
    quad_nxt.c1_x = sat(ext_c(o_side_r.start_x) - ext_o(o_x_r));
    quad_nxt.c1_y = sat(ext_c(o_side_r.start_y) - ext_o(o_y_r));
    quad_nxt.c2_x = sat(ext_c(o_side_r.end_x)   + ext_o(o_x_r));
    quad_nxt.c2_y = sat(ext_c(o_side_r.end_y)   + ext_o(o_y_r));
    quad_nxt.c3_x = sat(ext_c(o_side_r.start_x) + ext_o(o_x_r));
    quad_nxt.c3_y = sat(ext_c(o_side_r.start_y) + ext_o(o_y_r));
  end

  always_ff @(posedge clk) begin
    if (r_rdy) begin
      r_side_r <= up_side;
      r_x_r    <= rnd_x[RX_W-1:0];
      r_y_r    <= rnd_y[RX_W-1:0];
    end
    if (o_rdy) begin
      o_side_r <= r_side_r;
      o_x_r    <= ox_nxt;
      o_y_r    <= oy_nxt;
    end
    if (c_rdy) begin
      c_side_r <= o_side_r;
      c_quad_r <= quad_nxt;
    end
  end

  assign dn_valid = c_v_r;
  assign dn_side  = c_side_r;
  assign dn_quad  = c_quad_r;

endmodule
